[rtl/ctc_pkg.sv]
`default_nettype none

package ctc_pkg;

  localparam int unsigned TickWidth = 10;
  localparam logic [TickWidth-1:0] TickReset = TickWidth'(50);

  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_COOK      = 4'd10;
  localparam logic [3:0] KEY_CANCEL    = 4'd11;
  localparam logic [3:0] KEY_NONE      = 4'd12;

  localparam logic [3:0] UNITS_MAX = 4'd9;
  localparam logic [2:0] TENS_MAX  = 3'd5;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_SETTING = 2'd1,
    MODE_RUNNING = 2'd2
  } mode_t;

  typedef struct packed {
    logic [3:0] min_tens;
    logic [3:0] min_units;
    logic [2:0] sec_tens;
    logic [3:0] sec_units;
  } bcd_clock_t;

  typedef struct packed {
    mode_t      mode;
    logic       power_on;
    bcd_clock_t clock;
  } ctc_result_t;

endpackage

`default_nettype wire

[rtl/cooking_timer_controller.sv]
// an accepted input beat's result beat is on the output register in the next cycle
// throughput: one tick per cycle unless a stalled result holds in_stall; the mode/time update
//   is a single pass of logic between the state registers and the result register
// reset (rst, synchronous, active high): off mode, time 00:00, drive off,
//   prescaler and ticks_per_second at 50, no result pending
`default_nettype none

module cooking_timer_controller (
  input  logic       clk,
  input  logic       rst,
  // configuration write channel: ticks_per_second
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [9:0] cfg_data,
  // tick channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] key,
  input  logic       door_open,
  input  logic       weight_present,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] mode,
  output logic       power_on,
  output logic [3:0] minute_tens,
  output logic [3:0] minute_units,
  output logic [2:0] second_tens,
  output logic [3:0] second_units
);

  logic [ctc_pkg::TickWidth-1:0] ticks_per_second;
  ctc_pkg::ctc_result_t          result_next;
  ctc_pkg::ctc_result_t          result;
  logic                          in_accept;

  // config register is always writable; a new rate is picked up at the next reload
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= ctc_pkg::TickReset;
    end else if (cfg_valid && cfg_ready) begin
      ticks_per_second <= cfg_data;
    end
  end

  // take a new tick whenever the result register is empty or is draining this cycle
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  ctc_step u_step (
    .clk            (clk),
    .rst            (rst),
    .step_en        (in_accept),
    .key            (key),
    .door_open      (door_open),
    .weight_present (weight_present),
    .tps            (ticks_per_second),
    .result_next    (result_next)
  );

  // result register: valid bit under reset, payload loads on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result <= result_next;
    end
  end

  assign mode         = result.mode;
  assign power_on     = result.power_on;
  assign minute_tens  = result.clock.min_tens;
  assign minute_units = result.clock.min_units;
  assign second_tens  = result.clock.sec_tens;
  assign second_units = result.clock.sec_units;

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // every accepted tick leaves a result beat behind it
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted tick produced no result");

  // drive is never on while setting the time
  a_no_drive_setting: assert property (@(posedge clk) disable iff (rst)
    (out_valid && power_on) |-> (mode != ctc_pkg::MODE_SETTING))
    else $error("drive on in setting mode");

  // seconds digits stay in bcd range
  a_seconds_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (second_tens <= ctc_pkg::TENS_MAX && second_units <= ctc_pkg::UNITS_MAX))
    else $error("seconds digit out of range");

endmodule

`default_nettype wire

[rtl/ctc_bcd_down.sv]
`default_nettype none

module ctc_bcd_down (
  input  ctc_pkg::bcd_clock_t cur,
  output ctc_pkg::bcd_clock_t dec
);

  // mm:ss minus one second, borrow rippling up; all-zero stays zero
  always_comb begin
    dec = cur;
    if (cur.sec_units != 4'd0) begin
      dec.sec_units = cur.sec_units - 4'd1;
    end else if (cur.sec_tens != 3'd0) begin
      dec.sec_tens  = cur.sec_tens - 3'd1;
      dec.sec_units = ctc_pkg::UNITS_MAX;
    end else if (cur.min_units != 4'd0) begin
      dec.min_units = cur.min_units - 4'd1;
      dec.sec_tens  = ctc_pkg::TENS_MAX;
      dec.sec_units = ctc_pkg::UNITS_MAX;
    end else if (cur.min_tens != 4'd0) begin
      dec.min_tens  = cur.min_tens - 4'd1;
      dec.min_units = ctc_pkg::UNITS_MAX;
      dec.sec_tens  = ctc_pkg::TENS_MAX;
      dec.sec_units = ctc_pkg::UNITS_MAX;
    end
  end

endmodule

`default_nettype wire

[rtl/ctc_step.sv]
`default_nettype none

module ctc_step (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 step_en,
  input  logic [3:0]                           key,
  input  logic                                 door_open,
  input  logic                                 weight_present,
  input  logic [ctc_pkg::TickWidth-1:0]        tps,
  output ctc_pkg::ctc_result_t                 result_next
);

  ctc_pkg::mode_t      mode, mode_next;
  logic                entry_digit, entry_digit_next;
  logic [ctc_pkg::TickWidth-1:0] tick_count, tick_count_next;
  logic [ctc_pkg::TickWidth-1:0] tick_dec, reload;
  ctc_pkg::bcd_clock_t clock, clock_next, clock_dec;
  logic                drive, drive_next;
  logic [3:0]          key_n;
  logic                zero_time;

  ctc_bcd_down u_bcd_down (
    .cur (clock),
    .dec (clock_dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= ctc_pkg::MODE_OFF;
      entry_digit <= 1'b0;
      tick_count  <= ctc_pkg::TickReset;
      clock       <= '0;
      drive       <= 1'b0;
    end else if (step_en) begin
      mode        <= mode_next;
      entry_digit <= entry_digit_next;
      tick_count  <= tick_count_next;
      clock       <= clock_next;
      drive       <= drive_next;
    end
  end

  always_comb begin
    key_n     = (key > ctc_pkg::KEY_NONE) ? ctc_pkg::KEY_NONE : key;
    zero_time = (clock == '0);
    tick_dec  = tick_count - ctc_pkg::TickWidth'(1);
    reload    = (tps == '0) ? ctc_pkg::TickWidth'(1) : tps;

    mode_next        = mode;
    entry_digit_next = entry_digit;
    tick_count_next  = tick_count;
    clock_next       = clock;
    drive_next       = drive;

    case (mode)
      ctc_pkg::MODE_RUNNING: begin
        if (key_n == ctc_pkg::KEY_CANCEL || door_open || !weight_present || zero_time) begin
          mode_next = ctc_pkg::MODE_OFF;
        end else begin
          drive_next = 1'b1;
          if (tick_dec == '0) begin
            clock_next      = clock_dec;
            tick_count_next = reload;
          end else begin
            tick_count_next = tick_dec;
          end
        end
      end
      ctc_pkg::MODE_SETTING: begin
        if (key_n == ctc_pkg::KEY_CANCEL) begin
          clock_next       = '0;
          entry_digit_next = 1'b0;
        end else if (key_n == ctc_pkg::KEY_COOK) begin
          if (!door_open && weight_present &&
              (clock.min_tens != 4'd0 || clock.min_units != 4'd0)) begin
            mode_next = ctc_pkg::MODE_RUNNING;
          end
        end else if (key_n <= ctc_pkg::KEY_DIGIT_MAX) begin
          if (!entry_digit) begin
            clock_next.min_tens = key_n;
          end else begin
            clock_next.min_units = key_n;
          end
          entry_digit_next = ~entry_digit;
        end
      end
      default: begin
        // off, and the unused code acting as off
        clock_next       = '0;
        tick_count_next  = reload;
        drive_next       = 1'b0;
        entry_digit_next = 1'b0;
        mode_next        = ctc_pkg::MODE_SETTING;
      end
    endcase

    result_next.mode     = mode_next;
    result_next.power_on = drive_next;
    result_next.clock    = clock_next;
  end

endmodule

`default_nettype wire

[dv/cooking_timer_controller_test.sv]
module cooking_timer_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  // one line of the directed stimulus table
  typedef struct packed {
    logic [3:0]           k;
    logic                 door;
    logic                 load;
    logic [7:0]           reps;
    logic                 typed;
    ctc_pkg::ctc_result_t want;
  } tick_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;

  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [9:0] cfg_data = '0;

  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [3:0] key = ctc_pkg::KEY_NONE;
  logic       door_open = 1'b0;
  logic       weight_present = 1'b0;

  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] mode;
  logic       power_on;
  logic [3:0] minute_tens;
  logic [3:0] minute_units;
  logic [2:0] second_tens;
  logic [3:0] second_units;

  // display beats still owed by the block, oldest first
  ctc_pkg::ctc_result_t pending_displays[$];
  int          mismatches = 0;
  // when set, neither side idles or stalls
  bit          quiet = 1'b0;

  // predictor copy of the controller state and of ticks_per_second
  ctc_pkg::mode_t      cur_mode = ctc_pkg::MODE_OFF;
  logic                units_next = 1'b0;
  logic [9:0]          prescale = ctc_pkg::TickReset;
  logic [9:0]          rate = ctc_pkg::TickReset;
  ctc_pkg::bcd_clock_t time_left = '0;
  logic                drive = 1'b0;

  cooking_timer_controller dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .key            (key),
    .door_open      (door_open),
    .weight_present (weight_present),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .mode           (mode),
    .power_on       (power_on),
    .minute_tens    (minute_tens),
    .minute_units   (minute_units),
    .second_tens    (second_tens),
    .second_units   (second_units)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // display for a typed-in expectation
  function automatic ctc_pkg::ctc_result_t shown(ctc_pkg::mode_t m, logic p,
                                                 logic [3:0] mt, logic [3:0] mu,
                                                 logic [2:0] st, logic [3:0] su);
    ctc_pkg::ctc_result_t r;
    r.mode            = m;
    r.power_on        = p;
    r.clock.min_tens  = mt;
    r.clock.min_units = mu;
    r.clock.sec_tens  = st;
    r.clock.sec_units = su;
    return r;
  endfunction

  // next state of the controller for one tick, and the display it shows after it
  function automatic ctc_pkg::ctc_result_t advance_tick(logic [3:0] k, logic door,
                                                        logic load);
    logic [3:0]           kk;
    ctc_pkg::ctc_result_t r;
    // codes above no-key behave as no key
    kk = (k > ctc_pkg::KEY_NONE) ? ctc_pkg::KEY_NONE : k;
    case (cur_mode)
      ctc_pkg::MODE_RUNNING: begin
        if (kk == ctc_pkg::KEY_CANCEL || door || !load || time_left == '0) begin
          // drive stays on for this tick, the off tick clears it
          cur_mode = ctc_pkg::MODE_OFF;
        end else begin
          drive    = 1'b1;
          prescale = prescale - 10'd1;
          if (prescale == '0) begin
            // one second down with bcd borrow
            if (time_left.sec_units != 0) begin
              time_left.sec_units = time_left.sec_units - 4'd1;
            end else if (time_left.sec_tens != 0) begin
              time_left.sec_tens  = time_left.sec_tens - 3'd1;
              time_left.sec_units = ctc_pkg::UNITS_MAX;
            end else if (time_left.min_units != 0) begin
              time_left.min_units = time_left.min_units - 4'd1;
              time_left.sec_tens  = ctc_pkg::TENS_MAX;
              time_left.sec_units = ctc_pkg::UNITS_MAX;
            end else if (time_left.min_tens != 0) begin
              time_left.min_tens  = time_left.min_tens - 4'd1;
              time_left.min_units = ctc_pkg::UNITS_MAX;
              time_left.sec_tens  = ctc_pkg::TENS_MAX;
              time_left.sec_units = ctc_pkg::UNITS_MAX;
            end
            // a zero rate acts as one
            prescale = (rate == '0) ? 10'd1 : rate;
          end
        end
      end
      ctc_pkg::MODE_SETTING: begin
        if (kk == ctc_pkg::KEY_CANCEL) begin
          time_left  = '0;
          units_next = 1'b0;
        end else if (kk == ctc_pkg::KEY_COOK) begin
          if (!door && load && (time_left.min_tens != 0 || time_left.min_units != 0))
            cur_mode = ctc_pkg::MODE_RUNNING;
        end else if (kk <= ctc_pkg::KEY_DIGIT_MAX) begin
          if (!units_next) time_left.min_tens = kk;
          else time_left.min_units = kk;
          units_next = !units_next;
        end
      end
      default: begin
        // off, and the unused code: clear everything and move on to setting
        time_left  = '0;
        prescale   = (rate == '0) ? 10'd1 : rate;
        drive      = 1'b0;
        units_next = 1'b0;
        cur_mode   = ctc_pkg::MODE_SETTING;
      end
    endcase
    r.mode     = cur_mode;
    r.power_on = drive;
    r.clock    = time_left;
    return r;
  endfunction

  task automatic flag(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // one result beat against the oldest owed display
  task automatic check_beat();
    ctc_pkg::ctc_result_t want;
    if (pending_displays.size() == 0) begin
      flag("result beat with nothing pending, mode", mode, -1);
      return;
    end
    want = pending_displays.pop_front();
    if (mode !== want.mode) flag("mode", mode, want.mode);
    if (power_on !== want.power_on) flag("power_on", power_on, want.power_on);
    if (minute_tens !== want.clock.min_tens) flag("minute_tens", minute_tens, want.clock.min_tens);
    if (minute_units !== want.clock.min_units)
      flag("minute_units", minute_units, want.clock.min_units);
    if (second_tens !== want.clock.sec_tens) flag("second_tens", second_tens, want.clock.sec_tens);
    if (second_units !== want.clock.sec_units)
      flag("second_units", second_units, want.clock.sec_units);
  endtask

  // one tick beat: random gap, then hold it until accepted
  task automatic send_tick(input logic [3:0] k, input logic door, input logic load,
                           input logic typed, input ctc_pkg::ctc_result_t want);
    int                   gap;
    ctc_pkg::ctc_result_t got;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    key            <= k;
    door_open      <= door;
    weight_present <= load;
    do @(posedge clk); while (in_stall);
    // accepted at this edge, valid stays up until the next call decides
    got = advance_tick(k, door, load);
    pending_displays.push_back(typed ? want : got);
  endtask

  // new ticks_per_second, only once every owed display has come back
  task automatic write_rate(input logic [9:0] value);
    in_valid <= 1'b0;
    while (pending_displays.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rate = value;
  endtask

  // random ticks at one rate, mostly well-formed cooking sessions
  task automatic random_phase(input logic [9:0] value, input int count);
    int         pick;
    logic [3:0] k;
    logic       door;
    logic       load;
    write_rate(value);
    for (int n = 0; n < count; n++) begin
      // idling on or off in stretches of 40 beats
      if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      k    = ctc_pkg::KEY_NONE;
      door = 1'b0;
      load = 1'b1;
      if (pick < 12) begin
        // noise over the whole field range
        k    = 4'($urandom_range(0, 15));
        door = 1'($urandom_range(0, 1));
        load = 1'($urandom_range(0, 1));
      end else if (cur_mode == ctc_pkg::MODE_SETTING) begin
        // short times so that countdowns run to zero now and then
        if ((time_left.min_tens == 0 && time_left.min_units == 0) || units_next || pick < 30) begin
          if (units_next) k = 4'($urandom_range(0, 3));
          else k = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(1, 9)) : 4'd0;
        end else begin
          k = ctc_pkg::KEY_COOK;
        end
      end else if (cur_mode == ctc_pkg::MODE_RUNNING && pick < 15) begin
        case ($urandom_range(0, 3))
          0: k = ctc_pkg::KEY_CANCEL;
          1: door = 1'b1;
          2: load = 1'b0;
          default: k = 4'($urandom_range(0, 9));
        endcase
      end
      send_tick(k, door, load, 1'b0, '0);
    end
    quiet = 1'b0;
  endtask

  // result side: random stall after every accepted beat
  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        check_beat();
        hold = quiet ? 0 : $urandom_range(0, 4);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    tick_row_t plan[$];

    // directed table, run at one tick per second
    plan.push_back('{ctc_pkg::KEY_NONE, 1'b0, 1'b1, 8'd1, 1'b1,
                     shown(ctc_pkg::MODE_SETTING, 1'b0, 4'd0, 4'd0, 3'd0, 4'd0)});
    plan.push_back('{4'd9, 1'b0, 1'b1, 8'd1, 1'b1,
                     shown(ctc_pkg::MODE_SETTING, 1'b0, 4'd9, 4'd0, 3'd0, 4'd0)});
    plan.push_back('{4'd0, 1'b0, 1'b1, 8'd1, 1'b1,
                     shown(ctc_pkg::MODE_SETTING, 1'b0, 4'd9, 4'd0, 3'd0, 4'd0)});
    // unused key codes act as no key
    plan.push_back('{4'd13, 1'b1, 1'b0, 8'd1, 1'b0, '0});
    plan.push_back('{4'd15, 1'b0, 1'b1, 8'd1, 1'b0, '0});
    plan.push_back('{ctc_pkg::KEY_CANCEL, 1'b0, 1'b1, 8'd1, 1'b1,
                     shown(ctc_pkg::MODE_SETTING, 1'b0, 4'd0, 4'd0, 3'd0, 4'd0)});
    // start refused: zero minutes, door open, no load
    plan.push_back('{ctc_pkg::KEY_COOK, 1'b0, 1'b1, 8'd1, 1'b0, '0});
    plan.push_back('{4'd1, 1'b0, 1'b1, 8'd1, 1'b0, '0});
    plan.push_back('{4'd0, 1'b0, 1'b1, 8'd1, 1'b0, '0});
    plan.push_back('{ctc_pkg::KEY_COOK, 1'b1, 1'b1, 8'd1, 1'b0, '0});
    plan.push_back('{ctc_pkg::KEY_COOK, 1'b0, 1'b0, 8'd1, 1'b0, '0});
    // 10:00 runs, minute tens borrow on the first second
    plan.push_back('{ctc_pkg::KEY_COOK, 1'b0, 1'b1, 8'd1, 1'b0, '0});
    plan.push_back('{ctc_pkg::KEY_NONE, 1'b0, 1'b1, 8'd3, 1'b0, '0});
    plan.push_back('{4'd5, 1'b0, 1'b1, 8'd1, 1'b0, '0});
    plan.push_back('{4'd14, 1'b0, 1'b1, 8'd1, 1'b0, '0});
    // door opens while cooking
    plan.push_back('{ctc_pkg::KEY_NONE, 1'b1, 1'b1, 8'd1, 1'b0, '0});
    plan.push_back('{ctc_pkg::KEY_NONE, 1'b0, 1'b1, 8'd1, 1'b0, '0});
    // 01:00 counts all the way down, then the zero time ends the run
    plan.push_back('{4'd0, 1'b0, 1'b1, 8'd1, 1'b0, '0});
    plan.push_back('{4'd1, 1'b0, 1'b1, 8'd1, 1'b0, '0});
    plan.push_back('{ctc_pkg::KEY_COOK, 1'b0, 1'b1, 8'd1, 1'b0, '0});
    plan.push_back('{ctc_pkg::KEY_NONE, 1'b0, 1'b1, 8'd61, 1'b0, '0});
    plan.push_back('{ctc_pkg::KEY_NONE, 1'b0, 1'b1, 8'd1, 1'b0, '0});
    // load taken out while cooking
    plan.push_back('{4'd2, 1'b0, 1'b1, 8'd1, 1'b0, '0});
    plan.push_back('{4'd3, 1'b0, 1'b1, 8'd1, 1'b0, '0});
    plan.push_back('{ctc_pkg::KEY_COOK, 1'b0, 1'b1, 8'd1, 1'b0, '0});
    plan.push_back('{ctc_pkg::KEY_NONE, 1'b0, 1'b0, 8'd2, 1'b0, '0});
    // stop key while cooking
    plan.push_back('{4'd4, 1'b0, 1'b1, 8'd1, 1'b0, '0});
    plan.push_back('{ctc_pkg::KEY_COOK, 1'b0, 1'b1, 8'd2, 1'b0, '0});
    plan.push_back('{ctc_pkg::KEY_CANCEL, 1'b0, 1'b1, 8'd1, 1'b0, '0});
    plan.push_back('{ctc_pkg::KEY_NONE, 1'b0, 1'b1, 8'd1, 1'b0, '0});

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_rate(10'd1);
    foreach (plan[i])
      repeat (plan[i].reps) send_tick(plan[i].k, plan[i].door, plan[i].load, plan[i].typed,
                                      plan[i].want);

    // rate extremes, zero acting as one, and a few in between
    random_phase(10'd0, 100);
    random_phase(10'd1023, 90);
    random_phase(10'd3, 90);
    random_phase(10'd1, 100);
    random_phase(ctc_pkg::TickReset, 90);
    random_phase(10'($urandom_range(2, 1022)), 90);

    in_valid <= 1'b0;
    while (pending_displays.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin : watchdog
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
